/* sv/lz4bd_pkg.sv */
// ----------------------------------------------------------------------------
// lz4bd_pkg
// shared types and constants for the lz4 block decompressor
// ----------------------------------------------------------------------------
package lz4bd_pkg;

  localparam int unsigned HistoryDepthDefault = 32768;
  localparam logic [15:0] CapacityReset = 16'd28800;
  localparam logic [23:0] LenMax = 24'hFFFFFF;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_LITEXT,
    PH_LIT,
    PH_OFFLO,
    PH_OFFHI,
    PH_MEXT,
    PH_COPY,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic [14:0] out_index;
    logic        refused;
    logic        bad_offset;
    logic        block_done;
  } result_t;

endpackage

/* sv/lz4bd_queue.sv */
// ----------------------------------------------------------------------------
// lz4bd_queue
// small synchronous fifo of words with push/full and pop/empty
// ----------------------------------------------------------------------------
module lz4bd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = lz4bd_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |=> !(count == (AW+1)'(DEPTH)))
    else $error("queue jumped from empty to full");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance");

endmodule

/* sv/lz4bd_engine.sv */
// ----------------------------------------------------------------------------
// lz4bd_engine
// parser and copy engine: one word a cycle unless stalled, history in sync ram
// ----------------------------------------------------------------------------
module lz4bd_engine #(
  parameter int unsigned HISTORY_DEPTH = lz4bd_pkg::HistoryDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         capacity,
  input  logic                in_valid,
  input  lz4bd_pkg::item_t    in_item,
  output logic                in_ready,
  output logic                res_valid,
  output lz4bd_pkg::result_t  res,
  input  logic                res_ready
);

  localparam int unsigned HW = $clog2(HISTORY_DEPTH);
  localparam logic [16:0] Depth17 = 17'(HISTORY_DEPTH);

  logic [7:0] hist [HISTORY_DEPTH];

  lz4bd_pkg::phase_t phase, phase_next;
  logic [23:0] lit_rem, lit_rem_next;
  logic [23:0] match_rem, match_rem_next;
  logic [3:0]  nibble, nibble_next;
  logic [15:0] offset, offset_next;
  logic [16:0] wpos, wpos_next;
  logic [16:0] csrc, csrc_next;
  logic        end_seen, end_seen_next;

  // pending copy: read issued last cycle, write-back this cycle
  logic        cp_pend;
  logic [16:0] cp_wpos;
  logic [7:0]  rd_data;

  // output stage: every result word is registered here and held until res_ready
  logic               s2_valid;
  lz4bd_pkg::result_t s2_res;
  logic               s2_copy;

  logic        step;
  logic        have;
  lz4bd_pkg::result_t r;
  logic        rd_en;
  logic        wr_en;
  logic [HW-1:0] wr_addr;
  logic [7:0]  wr_data;
  logic [16:0] cap;
  logic [16:0] room;
  logic [23:0] mlen;
  logic [24:0] sum;
  logic        bad;

  assign step      = in_valid && in_ready;
  assign in_ready  = !s2_valid || res_ready;
  assign res_valid = s2_valid;

  always_comb begin
    res = s2_res;
    if (s2_copy) begin
      res.out_byte = rd_data;
    end
  end

  always_comb begin
    cap = ({1'b0, capacity} > Depth17) ? Depth17 : {1'b0, capacity};
  end

  always_comb begin
    phase_next     = phase;
    lit_rem_next   = lit_rem;
    match_rem_next = match_rem;
    nibble_next    = nibble;
    offset_next    = offset;
    wpos_next      = wpos;
    csrc_next      = csrc;
    end_seen_next  = end_seen;
    have           = 1'b0;
    r              = '0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = wpos[HW-1:0];
    wr_data        = in_item.data_byte;
    sum            = '0;
    mlen           = match_rem;
    room           = (cap > wpos) ? cap - wpos : '0;
    bad            = 1'b0;
    if (step) begin
      if (in_item.mode) begin
        if (phase == lz4bd_pkg::PH_COPY && match_rem != '0 &&
            csrc < Depth17 && wpos < Depth17) begin
          rd_en          = 1'b1;
          have           = 1'b1;
          r.byte_valid   = 1'b1;
          r.out_index    = wpos[14:0];
          wpos_next      = wpos + 1'b1;
          csrc_next      = csrc + 1'b1;
          match_rem_next = match_rem - 1'b1;
          if (match_rem == 24'd1) begin
            if (end_seen) begin
              r.block_done = 1'b1;
              phase_next = lz4bd_pkg::PH_TOKEN;
              wpos_next  = '0;
              csrc_next  = '0;
              lit_rem_next = '0;
              nibble_next  = '0;
              offset_next  = '0;
              end_seen_next = 1'b0;
            end else begin
              phase_next = lz4bd_pkg::PH_TOKEN;
            end
          end
        end
      end else if (phase == lz4bd_pkg::PH_COPY) begin
        have      = 1'b1;
        r.refused = 1'b1;
      end else begin
        case (phase)
          lz4bd_pkg::PH_TOKEN: begin
            nibble_next  = in_item.data_byte[3:0];
            lit_rem_next = {20'd0, in_item.data_byte[7:4]};
            if (in_item.data_byte[7:4] == 4'hF) begin
              phase_next = lz4bd_pkg::PH_LITEXT;
            end else if (in_item.data_byte[7:4] != 4'h0) begin
              phase_next = lz4bd_pkg::PH_LIT;
            end else begin
              phase_next = lz4bd_pkg::PH_OFFLO;
            end
          end
          lz4bd_pkg::PH_LITEXT: begin
            sum = {1'b0, lit_rem} + 25'(in_item.data_byte);
            lit_rem_next = (sum > {1'b0, lz4bd_pkg::LenMax}) ? lz4bd_pkg::LenMax
                                                             : sum[23:0];
            if (in_item.data_byte != 8'hFF) begin
              phase_next = (lit_rem_next != '0) ? lz4bd_pkg::PH_LIT
                                                : lz4bd_pkg::PH_OFFLO;
            end
          end
          lz4bd_pkg::PH_LIT: begin
            if (wpos < cap) begin
              wr_en        = 1'b1;
              have         = 1'b1;
              r.byte_valid = 1'b1;
              r.out_byte   = in_item.data_byte;
              r.out_index  = wpos[14:0];
              wpos_next    = wpos + 1'b1;
            end
            lit_rem_next = lit_rem - 1'b1;
            if (lit_rem == 24'd1) begin
              phase_next = lz4bd_pkg::PH_OFFLO;
            end
          end
          lz4bd_pkg::PH_OFFLO: begin
            offset_next = {8'd0, in_item.data_byte};
            phase_next  = lz4bd_pkg::PH_OFFHI;
          end
          lz4bd_pkg::PH_OFFHI: begin
            offset_next    = {in_item.data_byte, offset[7:0]};
            match_rem_next = 24'(nibble) + 24'd4;
            if (nibble == 4'hF) begin
              phase_next = lz4bd_pkg::PH_MEXT;
            end else begin
              mlen = match_rem_next;
              bad  = 1'b1;
            end
          end
          lz4bd_pkg::PH_MEXT: begin
            sum = {1'b0, match_rem} + 25'(in_item.data_byte);
            match_rem_next = (sum > {1'b0, lz4bd_pkg::LenMax}) ? lz4bd_pkg::LenMax
                                                               : sum[23:0];
            if (in_item.data_byte != 8'hFF) begin
              mlen = match_rem_next;
              bad  = 1'b1;
            end
          end
          default: begin
          end
        endcase
        // bad doubles as "start copy now"
        if (bad) begin
          if (offset_next == '0 || {1'b0, offset_next} > wpos) begin
            phase_next   = lz4bd_pkg::PH_ERROR;
            have         = 1'b1;
            r.bad_offset = 1'b1;
          end else begin
            if (mlen > 24'(room)) begin
              mlen = 24'(room);
            end
            match_rem_next = mlen;
            csrc_next      = wpos - 17'(offset_next);
            phase_next     = (mlen != '0) ? lz4bd_pkg::PH_COPY : lz4bd_pkg::PH_TOKEN;
          end
        end
        if (in_item.last_byte) begin
          if (phase_next == lz4bd_pkg::PH_COPY) begin
            end_seen_next = 1'b1;
          end else begin
            have          = 1'b1;
            r.block_done  = 1'b1;
            phase_next    = lz4bd_pkg::PH_TOKEN;
            lit_rem_next  = '0;
            match_rem_next = '0;
            nibble_next   = '0;
            offset_next   = '0;
            wpos_next     = '0;
            csrc_next     = '0;
            end_seen_next = 1'b0;
          end
        end
      end
    end
    // copy write-back of the byte read last cycle
    if (cp_pend) begin
      wr_en   = 1'b1;
      wr_addr = cp_wpos[HW-1:0];
      wr_data = rd_data;
    end
  end

  // a literal write and a copy write never coincide: a copy is followed only
  // by more drain ticks, refusals or a token until it finishes
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= (cp_pend && cp_wpos[HW-1:0] == csrc[HW-1:0]) ? rd_data
                                                               : hist[csrc[HW-1:0]];
    end
    if (wr_en) begin
      hist[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= lz4bd_pkg::PH_TOKEN;
      lit_rem   <= '0;
      match_rem <= '0;
      nibble    <= '0;
      offset    <= '0;
      wpos      <= '0;
      csrc      <= '0;
      end_seen  <= 1'b0;
      cp_pend   <= 1'b0;
      s2_valid  <= 1'b0;
    end else begin
      phase     <= phase_next;
      lit_rem   <= lit_rem_next;
      match_rem <= match_rem_next;
      nibble    <= nibble_next;
      offset    <= offset_next;
      wpos      <= wpos_next;
      csrc      <= csrc_next;
      end_seen  <= end_seen_next;
      cp_pend   <= rd_en;
      if (step) begin
        s2_valid <= have;
      end else if (res_ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cp_wpos <= wpos;
    end
    if (step) begin
      s2_res  <= r;
      s2_copy <= rd_en;
    end
  end

  a_wpos_cap: assert property (@(posedge clk) disable iff (rst)
    wpos <= Depth17)
    else $error("write position beyond history");

  a_copy_len: assert property (@(posedge clk) disable iff (rst)
    (phase == lz4bd_pkg::PH_COPY) |-> match_rem != '0)
    else $error("copy phase with nothing to copy");

  a_pend_follows: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> cp_pend)
    else $error("copy read lost");

endmodule

/* sv/lz4_block_decompressor.sv */
// ----------------------------------------------------------------------------
// lz4_block_decompressor
// raw lz4 block decoder, one compressed byte or one drain tick per word
// ----------------------------------------------------------------------------
// input queue: push a word (mode, data_byte, last_byte) when full is low.
// result queue: while empty is low the oldest result word is on the ports;
// pop takes it. a front queue holds incoming words, the engine parses one word
// a cycle, and a result queue decouples the consumer. throughput is one word
// per cycle while the result queue has room: every word steps the engine once;
// a drain tick reads the history in its step cycle and writes the copied byte
// back the next, with a bypass for overlapping copies, so drain ticks run back
// to back. every result passes one output stage and the result queue before it
// is on the ports. words that produce no result leave nothing in the result
// queue. if the consumer stalls the result queue fills, then the engine and
// the input queue stop and full rises. reset (rst, synchronous) empties both
// queues, restores output_capacity to 28800 and starts a new block; the
// history needs no clearing. the user must write output_capacity through
// cfg_valid/cfg_ready (always ready) only while the block is idle; unchecked.
// ----------------------------------------------------------------------------
module lz4_block_decompressor #(
  parameter int unsigned HISTORY_DEPTH = lz4bd_pkg::HistoryDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic        byte_valid,
  output logic [7:0]  out_byte,
  output logic [14:0] out_index,
  output logic        refused,
  output logic        bad_offset,
  output logic        block_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] output_capacity;
  lz4bd_pkg::item_t   in_word, eng_item;
  lz4bd_pkg::result_t eng_res, out_res;
  logic in_empty, eng_ready, res_valid, out_full;

  assign cfg_ready = 1'b1;
  assign in_word   = '{mode: mode, data_byte: data_byte, last_byte: last_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= lz4bd_pkg::CapacityReset;
    end else if (cfg_valid && cfg_ready) begin
      output_capacity <= cfg_data;
    end
  end

  lz4bd_queue #(.WIDTH($bits(lz4bd_pkg::item_t))) u_in_q (
    .clk(clk), .rst(rst),
    .push(push), .wdata(in_word), .full(full),
    .pop(eng_ready), .rdata(eng_item), .empty(in_empty)
  );

  // engine advances while its output stage is empty or the result queue can take one more word
  logic res_room;

  lz4bd_engine #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_engine (
    .clk(clk), .rst(rst), .capacity(output_capacity),
    .in_valid(!in_empty), .in_item(eng_item), .in_ready(eng_ready),
    .res_valid(res_valid), .res(eng_res), .res_ready(res_room)
  );

  lz4bd_queue #(.WIDTH($bits(lz4bd_pkg::result_t))) u_out_q (
    .clk(clk), .rst(rst),
    .push(res_valid && res_room), .wdata(eng_res), .full(out_full),
    .pop(pop), .rdata(out_res), .empty(empty)
  );

  assign res_room = !out_full;

  assign byte_valid = out_res.byte_valid;
  assign out_byte   = out_res.out_byte;
  assign out_index  = out_res.out_index;
  assign refused    = out_res.refused;
  assign bad_offset = out_res.bad_offset;
  assign block_done = out_res.block_done;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// lz4 block decompressor testbench: builds lz4 blocks word by word, mirrors
// the decoder in a behavioral model and compares every result word, field by
// field, against the expected queue while both sides idle at random
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned Depth = 32768;
  localparam int unsigned IdleLimit = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        mode = 1'b0;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        byte_valid;
  logic [7:0]  out_byte;
  logic [14:0] out_index;
  logic        refused;
  logic        bad_offset;
  logic        block_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;

  lz4_block_decompressor dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode),
    .data_byte(data_byte), .last_byte(last_byte), .empty(empty), .pop(pop),
    .byte_valid(byte_valid), .out_byte(out_byte), .out_index(out_index),
    .refused(refused), .bad_offset(bad_offset), .block_done(block_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // decoder model state
  lz4bd_pkg::phase_t ph;
  int unsigned capacity;
  int unsigned lit_left, match_left, match_nib, offset, wpos, csrc;
  bit          end_pending;
  logic [7:0]  hist [Depth];

  lz4bd_pkg::result_t expected_words [$];
  int          errors = 0;
  int          words_sent = 0;
  bit          calm = 1'b0;
  int          idle_cycles = 0;

  // block builder state
  int          blk_count, blk_budget;
  bit          blk_ended;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_block();
    ph = lz4bd_pkg::PH_TOKEN;
    lit_left = 0;
    match_left = 0;
    match_nib = 0;
    offset = 0;
    wpos = 0;
    csrc = 0;
    end_pending = 1'b0;
  endfunction

  function automatic int unsigned sat_len(int unsigned a, int unsigned b);
    return (a + b > lz4bd_pkg::LenMax) ? lz4bd_pkg::LenMax : a + b;
  endfunction

  function automatic bit begin_copy();
    int unsigned cap, room;
    cap = (capacity > Depth) ? Depth : capacity;
    if (offset == 0 || offset > wpos) begin
      ph = lz4bd_pkg::PH_ERROR;
      return 1'b1;
    end
    room = (cap > wpos) ? cap - wpos : 0;
    if (match_left > room) match_left = room;
    csrc = wpos - offset;
    ph = (match_left != 0) ? lz4bd_pkg::PH_COPY : lz4bd_pkg::PH_TOKEN;
    return 1'b0;
  endfunction

  function automatic void decode_word(bit m, logic [7:0] b, bit lst);
    lz4bd_pkg::result_t r;
    bit          have;
    int unsigned cap;
    r = '0;
    have = 1'b0;
    cap = (capacity > Depth) ? Depth : capacity;
    if (m) begin
      if (ph != lz4bd_pkg::PH_COPY || match_left == 0 || csrc >= Depth || wpos >= Depth)
        return;
      r.out_byte = hist[csrc];
      hist[wpos] = hist[csrc];
      r.byte_valid = 1'b1;
      r.out_index = wpos[14:0];
      have = 1'b1;
      wpos++;
      csrc++;
      match_left--;
      if (match_left == 0) begin
        if (end_pending) begin
          r.block_done = 1'b1;
          clear_block();
        end else begin
          ph = lz4bd_pkg::PH_TOKEN;
        end
      end
    end else if (ph == lz4bd_pkg::PH_COPY) begin
      r.refused = 1'b1;
      have = 1'b1;
    end else begin
      case (ph)
        lz4bd_pkg::PH_TOKEN: begin
          match_nib = b[3:0];
          lit_left = b[7:4];
          if (lit_left == 15) ph = lz4bd_pkg::PH_LITEXT;
          else ph = (lit_left != 0) ? lz4bd_pkg::PH_LIT : lz4bd_pkg::PH_OFFLO;
        end
        lz4bd_pkg::PH_LITEXT: begin
          lit_left = sat_len(lit_left, b);
          if (b != 8'hFF) ph = (lit_left != 0) ? lz4bd_pkg::PH_LIT : lz4bd_pkg::PH_OFFLO;
        end
        lz4bd_pkg::PH_LIT: begin
          if (wpos < cap) begin
            hist[wpos] = b;
            r.byte_valid = 1'b1;
            r.out_byte = b;
            r.out_index = wpos[14:0];
            have = 1'b1;
            wpos++;
          end
          lit_left--;
          if (lit_left == 0) ph = lz4bd_pkg::PH_OFFLO;
        end
        lz4bd_pkg::PH_OFFLO: begin
          offset = b;
          ph = lz4bd_pkg::PH_OFFHI;
        end
        lz4bd_pkg::PH_OFFHI: begin
          offset = offset | (int'(b) << 8);
          match_left = match_nib + 4;
          if (match_nib == 15) begin
            ph = lz4bd_pkg::PH_MEXT;
          end else if (begin_copy()) begin
            r.bad_offset = 1'b1;
            have = 1'b1;
          end
        end
        lz4bd_pkg::PH_MEXT: begin
          match_left = sat_len(match_left, b);
          if (b != 8'hFF && begin_copy()) begin
            r.bad_offset = 1'b1;
            have = 1'b1;
          end
        end
        default: ;
      endcase
      if (lst) begin
        if (ph == lz4bd_pkg::PH_COPY) begin
          end_pending = 1'b1;
        end else begin
          r.block_done = 1'b1;
          have = 1'b1;
          clear_block();
        end
      end
    end
    if (have) expected_words.push_back(r);
  endfunction

  task automatic send_word(bit m, logic [7:0] b, bit lst);
    if (!calm && $urandom_range(99) < 14) begin
      do begin
        push <= 1'b0;
        @(posedge clk);
      end while ($urandom_range(99) < 30);
    end
    push <= 1'b1;
    mode <= m;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (full);
    decode_word(m, b, lst);
    words_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(int unsigned value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity = value;
  endtask

  // drain ticks until the pending copy is done, with an odd refused byte
  task automatic drain_copy();
    while (ph == lz4bd_pkg::PH_COPY) begin
      if ($urandom_range(99) < 4) send_word(1'b0, $urandom_range(255), $urandom_range(1));
      else send_word(1'b1, $urandom_range(255), $urandom_range(1));
    end
  endtask

  task automatic open_block(int budget);
    blk_count = 0;
    blk_budget = budget;
    blk_ended = 1'b0;
  endtask

  task automatic put(logic [7:0] b, bit force_last);
    bit lst;
    if (blk_ended) return;
    lst = force_last || (blk_count + 1 == blk_budget);
    send_word(1'b0, b, lst);
    blk_count++;
    if (lst) blk_ended = 1'b1;
    drain_copy();
  endtask

  task automatic put_ext(int unsigned rest, bit lst);
    while (rest >= 255) begin
      put(8'hFF, 1'b0);
      rest -= 255;
    end
    put(rest[7:0], lst);
  endtask

  // offset kinds: 0 any valid, 1 short overlap, 2 zero, 3 past block start
  function automatic int unsigned pick_offset(int kind);
    case (kind)
      0: return (wpos == 0) ? 1 : $urandom_range(wpos, 1);
      1: return (wpos < 4) ? 1 : $urandom_range(4, 1);
      2: return 0;
      default: return (wpos >= 65535) ? 0 : $urandom_range(65535, wpos + 1);
    endcase
  endfunction

  task automatic put_sequence(int unsigned lits, int unsigned mlen, int kind, bit lst_token);
    int unsigned ln, mn, off;
    int          i;
    ln = (lits >= 15) ? 15 : lits;
    mn = (mlen - 4 >= 15) ? 15 : mlen - 4;
    put({ln[3:0], mn[3:0]}, lst_token && lits == 0);
    if (ln == 15) put_ext(lits - 15, lst_token && lits == 15);
    for (i = 0; i < lits; i++) put($urandom_range(255), lst_token && i == lits - 1);
    if (lst_token) return;
    off = pick_offset(kind);
    put(off[7:0], 1'b0);
    put(off[15:8], 1'b0);
    if (mn == 15) put_ext(mlen - 19, 1'b0);
  endtask

  task automatic random_block();
    int n, s, kind, lits, mlen, k;
    open_block(($urandom_range(99) < 15) ? $urandom_range(60, 1) : 1 << 30);
    n = $urandom_range(5);
    for (s = 0; s < n; s++) begin
      k = $urandom_range(99);
      lits = (k < 70) ? $urandom_range(8) : (k < 95) ? $urandom_range(40, 9) :
             $urandom_range(600, 200);
      k = $urandom_range(99);
      mlen = (k < 70) ? $urandom_range(18, 4) : (k < 95) ? $urandom_range(80, 19) :
             $urandom_range(700, 270);
      k = $urandom_range(99);
      kind = (k < 45) ? 0 : (k < 88) ? 1 : (k < 94) ? 2 : 3;
      put_sequence(lits, mlen, kind, 1'b0);
    end
    put_sequence($urandom_range(12), 4, 0, 1'b1);
  endtask

  task automatic test_literals();
    open_block(1 << 30);
    put_sequence(3, 4, 0, 1'b0);
    put(8'h0F, 1'b0);
    put(8'h01, 1'b0);
    put(8'h00, 1'b0);
    put_sequence(2, 4, 0, 1'b1);
    open_block(1 << 30);
    put(8'h00, 1'b1);
    open_block(1 << 30);
    put(8'hF0, 1'b0);
    put(8'h00, 1'b0);
    repeat (14) put($urandom_range(255), 1'b0);
    put(8'hFF, 1'b0);
    put(8'h00, 1'b1);
  endtask

  task automatic test_matches();
    open_block(1 << 30);
    put_sequence(1, 9, 1, 1'b0);
    put_sequence(2, 300, 1, 1'b0);
    put_sequence(4, 23, 0, 1'b0);
    put_sequence(0, 4, 0, 1'b1);
    // block ending on a match
    open_block(1 << 30);
    put_sequence(5, 6, 0, 1'b0);
    open_block(1 << 30);
    put(8'h25, 1'b0);
    put(8'hAA, 1'b0);
    put(8'h55, 1'b0);
    put(8'h02, 1'b0);
    put(8'h00, 1'b1);
  endtask

  task automatic test_bad_offset();
    open_block(1 << 30);
    put_sequence(2, 4, 2, 1'b0);
    put_sequence(3, 5, 0, 1'b0);
    put_sequence(0, 4, 0, 1'b1);
    open_block(1 << 30);
    put_sequence(3, 30, 3, 1'b0);
    put(8'h00, 1'b1);
    open_block(1 << 30);
    put(8'h0F, 1'b0);
    put(8'hFF, 1'b0);
    put(8'hFF, 1'b1);
  endtask

  task automatic test_truncated_and_stray();
    int cut;
    send_word(1'b1, 8'h00, 1'b1);
    for (cut = 1; cut <= 9; cut++) begin
      open_block(cut);
      put_sequence(3, 5, 0, 1'b0);
      put_sequence(2, 4, 0, 1'b1);
    end
    send_word(1'b1, 8'hFF, 1'b0);
  endtask

  task automatic test_capacity();
    write_capacity(0);
    open_block(1 << 30);
    put_sequence(5, 8, 0, 1'b0);
    put_sequence(2, 4, 0, 1'b1);
    write_capacity(6);
    open_block(1 << 30);
    put_sequence(4, 10, 1, 1'b0);
    put_sequence(3, 4, 1, 1'b0);
    put_sequence(2, 4, 0, 1'b1);
    write_capacity(28800);
    open_block(1 << 30);
    put_sequence(6, 5, 0, 1'b0);
    write_capacity(3);
    put_sequence(2, 7, 0, 1'b0);
    write_capacity(40);
    put_sequence(2, 4, 0, 1'b1);
    // top capacity value, no idling
    write_capacity(32768);
    calm = 1'b1;
    open_block(1 << 30);
    put_sequence(1, 100, 1, 1'b0);
    put_sequence(3, 4, 0, 1'b1);
    calm = 1'b0;
  endtask

  task automatic test_long_lengths();
    int i;
    write_capacity(20);
    calm = 1'b1;
    open_block(1 << 30);
    put_sequence(2, 4, 0, 1'b0);
    put(8'h0F, 1'b0);
    put(8'h01, 1'b0);
    put(8'h00, 1'b0);
    for (i = 0; i < 3; i++) put(8'hFF, 1'b0);
    put(8'h10, 1'b0);
    put(8'hF0, 1'b0);
    for (i = 0; i < 3; i++) put(8'hFF, 1'b0);
    put(8'h07, 1'b0);
    put($urandom_range(255), 1'b1);
    calm = 1'b0;
  endtask

  task automatic test_random();
    int unsigned caps [6];
    int          p, stop_at;
    caps = '{28800, 32768, 0, 1, 150, 2000};
    stop_at = words_sent + 1500;
    p = 0;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 10) write_capacity(caps[p++ % 6]);
      if ($urandom_range(99) < 5) wait_drained();
      calm = (words_sent > stop_at - 1300 && words_sent < stop_at - 1000);
      random_block();
    end
    calm = 1'b0;
    write_capacity($urandom_range(32768));
    open_block(1 << 30);
    random_block();
  endtask

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    lz4bd_pkg::result_t e;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time,
                   {byte_valid, out_byte, out_index, refused, bad_offset, block_done});
          errors++;
        end else begin
          e = expected_words.pop_front();
          check_field("byte_valid", e.byte_valid, byte_valid);
          check_field("out_byte", e.out_byte, out_byte);
          check_field("out_index", e.out_index, out_index);
          check_field("refused", e.refused, refused);
          check_field("bad_offset", e.bad_offset, bad_offset);
          check_field("block_done", e.block_done, block_done);
        end
      end
      pop <= calm || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    capacity = lz4bd_pkg::CapacityReset;
    clear_block();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_literals();
    test_matches();
    test_bad_offset();
    test_truncated_and_stray();
    wait_drained();
    test_capacity();
    test_long_lengths();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
